// ----- rtl/cht_pkg.sv -----
// Shared types and constants for the chained hash table unit.
// Holds the status codes, controller states and the command/status structs.
// No dependencies.
package cht_pkg;

    // Request opcodes.
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Value returned when nothing is found and for every put.
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    // Hash arithmetic: bucket = (HASH_MUL * key + HASH_ADD) mod buckets.
    localparam int HASH_MUL = 37;
    localparam int HASH_ADD = 43;
    // Width of the biased product and of one remainder digit per cycle.
    localparam int HASH_W = 40;
    localparam int DIGIT_W = 8;
    localparam int DIV_STEPS = HASH_W / DIGIT_W;
    localparam int STEP_W = $clog2(DIV_STEPS);
    // The signed product magnitude stays below this bound.
    localparam logic [63:0] HASH_SPAN = 64'h0000_0020_0000_0000;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DIV,
        S_FILL_RD,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    hash_en;
        logic    div_en;
        logic    clr_en;
        logic    fill_rd;
        logic    put_commit;
        logic    scan_init;
        logic    scan_rd;
        logic    scan_next;
        logic    set_res;
        status_t res_status;
        logic    res_found;
        logic    res_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic is_get;
        logic fill_full;
        logic fill_zero;
        logic key_match;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/cht_req_if.sv -----
// Request channel of the chained hash table unit: valid/ready plus payload.
// Depends on cht_pkg.
interface cht_req_if
    import cht_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] key;
    logic signed [31:0] data_in;

    modport source (output valid, output cmd, output key, output data_in, input ready);
    modport sink   (input valid, input cmd, input key, input data_in, output ready);
endinterface

// ----- rtl/cht_rsp_if.sv -----
// Response channel of the chained hash table unit: valid/ready plus payload.
// Depends on cht_pkg for the status type.
interface cht_rsp_if
    import cht_pkg::*;
();
    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [31:0] data_out;
    logic        [6:0]  bucket_index;

    modport source (output valid, output status, output data_out, output bucket_index,
                    input ready);
    modport sink   (input valid, input status, input data_out, input bucket_index,
                    output ready);
endinterface

// ----- rtl/cht_ctrl.sv -----
// Controller state machine of the chained hash table unit.
// Sequences clearing, hashing, fill lookup, bucket scan and result delivery.
// Depends on cht_pkg.
module cht_ctrl
    import cht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.is_get || stat.fill_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.key_match || stat.scan_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic: commands to the datapath.
    always_comb
    begin
        cmd = '0;
        cmd.res_status = ST_OK;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_req = in_valid;
            end
            S_HASH:
            begin
                cmd.hash_en = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_en = 1'b1;
            end
            S_FILL_RD:
            begin
                cmd.fill_rd = 1'b1;
            end
            S_DECIDE:
            begin
                cmd.scan_init = 1'b1;
                if (!stat.is_get)
                begin
                    cmd.set_res = 1'b1;
                    cmd.put_commit = !stat.fill_full;
                    cmd.res_status = stat.fill_full ? ST_FULL : ST_OK;
                end
                else if (stat.fill_zero)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
            end
            S_SCAN_CMP:
            begin
                if (stat.key_match)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found = 1'b1;
                end
                else if (stat.scan_last)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_RESULT:
            begin
                cmd.res_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A compare always follows the slot read that feeds it.
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CMP) |-> ($past(state_reg) == S_SCAN_RD))
        else $error("scan compare without a preceding slot read");

    // The bucket scan only runs for get requests.
    a_scan_only_get: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD) |-> stat.is_get)
        else $error("bucket scan started for a put");

endmodule

// ----- rtl/cht_dp.sv -----
// Datapath of the chained hash table unit: request registers, hash and
// remainder unit, fill-count and slot memories, pending and output registers.
// Depends on cht_pkg.
module cht_dp
    import cht_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int WAYS    = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         stat,
    input  logic               in_cmd,
    input  logic signed [31:0] in_key,
    input  logic signed [31:0] in_data,
    input  logic               out_ready,
    output logic               out_valid,
    output status_t            out_status,
    output logic signed [31:0] out_data,
    output logic        [6:0]  out_bucket
);

    localparam int B_W        = $clog2(BUCKETS);
    localparam int R_W        = B_W + 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W     = $clog2(WAYS + 1);
    localparam int A_W        = B_W + WAY_W;
    localparam int SLOT_DEPTH = BUCKETS << WAY_W;
    // Bias that makes the product non-negative without changing its residue.
    localparam logic [63:0] HASH_OFS64 =
        (HASH_SPAN + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS) * 64'(BUCKETS);
    localparam logic [HASH_W-1:0] HASH_OFS = HASH_OFS64[HASH_W-1:0];

    // Request registers.
    logic        cmd_reg;
    logic [31:0] key_reg;
    logic [31:0] data_reg;

    // Hash and remainder registers.
    logic [HASH_W-1:0] u_reg;
    logic [B_W-1:0]    rem_reg;
    logic [B_W-1:0]    rem_next;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] key_ext;
    logic [HASH_W-1:0] hash_prod;

    // Memories and their read registers.
    logic [FILL_W-1:0] fill_mem [BUCKETS];
    logic [63:0]       slot_mem [SLOT_DEPTH];
    logic [FILL_W-1:0] fill_q;
    logic [63:0]       slot_q;
    logic [B_W-1:0]    clr_cnt_reg;
    logic [FILL_W-1:0] idx_reg;
    logic [A_W-1:0]    slot_wr_addr;
    logic [A_W-1:0]    slot_rd_addr;
    logic              fill_we;
    logic [B_W-1:0]    fill_wr_addr;
    logic [FILL_W-1:0] fill_wr_data;

    // Pending and output registers.
    status_t     pend_status_reg;
    logic [31:0] pend_data_reg;
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_data_reg;
    logic [6:0]  out_bucket_reg;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg  <= in_cmd;
            key_reg  <= in_key;
            data_reg <= in_data;
        end
    end

    // Biased hash product: 37 * key + 43 + bias, always in [0, 2^39).
    assign key_ext   = {{(HASH_W - 32){key_reg[31]}}, key_reg};
    assign hash_prod = HASH_W'(HASH_MUL) * key_ext + HASH_W'(HASH_ADD) + HASH_OFS;

    // One remainder digit per cycle: eight restoring steps on a narrow value.
    always_comb
    begin
        logic [R_W-1:0]     r;
        logic [DIGIT_W-1:0] digit;
        digit = u_reg[HASH_W-1 -: DIGIT_W];
        r = {1'b0, rem_reg};
        for (int j = DIGIT_W - 1; j >= 0; j--)
        begin
            r = {r[R_W-2:0], digit[j]};
            if (r >= R_W'(BUCKETS))
            begin
                r = r - R_W'(BUCKETS);
            end
        end
        rem_next = r[B_W-1:0];
    end

    // Hash and remainder sequencing.
    always_ff @(posedge clk)
    begin
        if (cmd.hash_en)
        begin
            u_reg    <= hash_prod;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_en)
        begin
            u_reg    <= u_reg << DIGIT_W;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
    end

    // Clear counter for the fill-count sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Fill-count memory: one write port shared by the sweep and by puts.
    assign fill_we      = cmd.clr_en || cmd.put_commit;
    assign fill_wr_addr = cmd.clr_en ? clr_cnt_reg : rem_reg;
    assign fill_wr_data = cmd.clr_en ? '0 : FILL_W'(fill_q + 1'b1);

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_wr_addr] <= fill_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_rd)
        begin
            fill_q <= fill_mem[rem_reg];
        end
    end

    // Scan index within the bucket.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_next)
        begin
            idx_reg <= FILL_W'(idx_reg + 1'b1);
        end
    end

    // Slot memory: key in the upper half, value in the lower half.
    assign slot_wr_addr = {rem_reg, WAY_W'(fill_q)};
    assign slot_rd_addr = {rem_reg, WAY_W'(idx_reg)};

    always_ff @(posedge clk)
    begin
        if (cmd.put_commit)
        begin
            slot_mem[slot_wr_addr] <= {key_reg, data_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            slot_q <= slot_mem[slot_rd_addr];
        end
    end

    // Pending result, held until the output register is free.
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            pend_status_reg <= cmd.res_status;
            pend_data_reg   <= cmd.res_found ? slot_q[31:0] : INT_MIN;
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_data_reg;
            out_bucket_reg <= 7'(rem_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = $signed(out_data_reg);
    assign out_bucket = out_bucket_reg;

    // Status back to the controller.
    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == B_W'(BUCKETS - 1));
        stat.div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
        stat.is_get    = (cmd_reg == CMD_GET);
        stat.fill_full = (fill_q >= FILL_W'(WAYS));
        stat.fill_zero = (fill_q == '0);
        stat.key_match = (slot_q[63:32] == key_reg);
        stat.scan_last = (FILL_W'(idx_reg + 1'b1) == fill_q);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // A put never lands in a bucket that is already full.
    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_commit |-> (!stat.fill_full && !stat.is_get))
        else $error("slot write into a full bucket or on a get");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

    // Fill counts read back never exceed the bucket size.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.fill_rd) |-> (fill_q <= FILL_W'(WAYS)))
        else $error("bucket fill count out of range");

endmodule

// ----- rtl/chained_hash_table_unit.sv -----
// Chained hash table unit: top level joining controller and datapath.
// A put runs the hash, remainder, fill-read and decide states; a get also
// reads and compares slots in turn. Throughput: one transaction at a time;
// the 5-step remainder unit (8 bits a cycle) and single slot read port set it.
// Reset: after rst_n releases, a sweep of BUCKETS cycles clears the fill counts
// while the request channel is held not ready. Depends on cht_pkg.
module chained_hash_table_unit
    import cht_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int WAYS    = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_stat;

    // Sequencer.
    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // Storage, hashing and result registers.
    cht_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .stat       (dp_stat),
        .in_cmd     (req.cmd),
        .in_key     (req.key),
        .in_data    (req.data_in),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_data   (rsp.data_out),
        .out_bucket (rsp.bucket_index)
    );

endmodule
